FILE: rtl/packed_glyph_alpha_unpacker_defines.svh
// Assertion macros for the packed glyph alpha unpacker checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef PACKED_GLYPH_ALPHA_UNPACKER_DEFINES_SVH
`define PACKED_GLYPH_ALPHA_UNPACKER_DEFINES_SVH

// Same-cycle implication, off during reset
`define PGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define PGA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked through reset as well
`define PGA_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pga_pkg.sv
// Package for the packed glyph alpha unpacker: types, register indexes, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pga_pkg;

  // Register index (paddr[3:2])
  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    logic [2:0] bits_per_pixel;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
  } cfg_t;

  // Clamp pixel width into 1..4
  function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
    logic [2:0] res;
    res = bpp;
    if (bpp == 3'd0) res = 3'd1;
    else if (bpp > 3'd4) res = 3'd4;
    return res;
  endfunction

  // code * 255 / (2^bpp - 1), floored; bpp already clamped
  function automatic logic [7:0] alpha_of(input logic [3:0] code, input logic [2:0] bpp);
    logic [7:0] res;
    res = 8'd0;
    unique case (bpp)
      3'd1: res = {8{code[0]}};
      3'd2: res = {4{code[1:0]}};
      3'd3: begin
        unique case (code[2:0])
          3'd0: res = 8'd0;
          3'd1: res = 8'd36;
          3'd2: res = 8'd72;
          3'd3: res = 8'd109;
          3'd4: res = 8'd145;
          3'd5: res = 8'd182;
          3'd6: res = 8'd218;
          3'd7: res = 8'd255;
          default: res = 8'd0;
        endcase
      end
      3'd4: res = {code, code};
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pga_cfg_regs.sv
// Configuration register block with APB-style access.
// Depends on pga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pga_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output pga_pkg::cfg_t       cfg
);

  logic [2:0] bpp_r;
  logic [7:0] width_r;
  logic [7:0] height_r;
  logic       wr_en;

  // Write strobe in the access phase; the port never waits
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 3'd1;
      width_r  <= 8'd1;
      height_r <= 8'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pga_pkg::REG_BPP:    bpp_r    <= pwdata[2:0];
        pga_pkg::REG_WIDTH:  width_r  <= pwdata[7:0];
        pga_pkg::REG_HEIGHT: height_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = 32'd0;
    unique case (paddr[3:2])
      pga_pkg::REG_BPP:    prdata = {29'd0, bpp_r};
      pga_pkg::REG_WIDTH:  prdata = {24'd0, width_r};
      pga_pkg::REG_HEIGHT: prdata = {24'd0, height_r};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg.bits_per_pixel = bpp_r;
  assign cfg.glyph_width    = width_r;
  assign cfg.glyph_height   = height_r;

endmodule

`default_nettype wire

FILE: rtl/pga_pixel_unit.sv
// Pixel extract unit: takes the top code off the bit buffer and scales it.
// Depends on pga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pga_pixel_unit (
  input  wire logic [15:0] bit_buf,
  input  wire logic [2:0]  bpp,
  output logic [7:0]       alpha,
  output logic [15:0]      bit_buf_shifted
);

  logic [3:0] code;

  // Code sits left aligned at bit 15
  always_comb begin
    code            = 4'd0;
    bit_buf_shifted = bit_buf;
    unique case (bpp)
      3'd1: begin
        code            = {3'd0, bit_buf[15]};
        bit_buf_shifted = {bit_buf[14:0], 1'b0};
      end
      3'd2: begin
        code            = {2'd0, bit_buf[15:14]};
        bit_buf_shifted = {bit_buf[13:0], 2'b0};
      end
      3'd3: begin
        code            = {1'b0, bit_buf[15:13]};
        bit_buf_shifted = {bit_buf[12:0], 3'b0};
      end
      3'd4: begin
        code            = bit_buf[15:12];
        bit_buf_shifted = {bit_buf[11:0], 4'b0};
      end
      default: begin
        code            = 4'd0;
        bit_buf_shifted = bit_buf;
      end
    endcase
  end

  assign alpha = pga_pkg::alpha_of(code, bpp);

endmodule

`default_nettype wire

FILE: rtl/packed_glyph_alpha_unpacker.sv
// Packed glyph alpha unpacker: top level with sequencer, bit buffer and output register.
// Depends on pga_pkg, pga_cfg_regs and pga_pixel_unit.
//
// Usage:
//   in_*  : one packed glyph byte per transaction, pixel codes MSB first.
//   out_* : one transaction per pixel: x, y and alpha in tdata, tlast on the
//           final pixel of the glyph.
//   cfg_* : APB-style registers bits_per_pixel (0x0), glyph_width (0x4),
//           glyph_height (0x8); write only while the block is idle.
// Flow: a byte is taken in the idle state, then the pixel unit peels one
//   pixel per cycle off the bit buffer while the output slot is free, until
//   the run is done. in_tready is low meanwhile.
//   The first pixel goes from the run state through the output register to out_*.
// A byte is dropped, with no output, when width or height is zero.
// After the last pixel the position and bit buffer clear for the next glyph.
// Reset: registers go to 1, buffer and position clear, out_tvalid drops.
// Stall: while out_tready is low the pending pixel holds and the sequencer
//   waits; one byte may be accepted meanwhile once the sequencer is idle.
`timescale 1ns / 1ps
`default_nettype none

module packed_glyph_alpha_unpacker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [7:0] pixel_x, [15:8] pixel_y, [23:16] alpha
  output logic             out_tlast,   // last_pixel
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  pga_pkg::cfg_t   cfg;
  pga_pkg::state_t state_r, state_nxt;

  logic [15:0] buf_r, buf_nxt;
  logic [3:0]  held_r, held_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  logic [2:0]  bpp;
  logic        geom_ok;
  logic        in_acc;
  logic        slot_free;
  logic        emit;
  logic [7:0]  alpha;
  logic [15:0] buf_shifted;
  logic [3:0]  held_after;
  logic        row_end;
  logic        last;
  logic        run_done;

  assign cfg_pready = 1'b1;

  pga_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  pga_pixel_unit u_pix (
    .bit_buf         (buf_r),
    .bpp             (bpp),
    .alpha           (alpha),
    .bit_buf_shifted (buf_shifted)
  );

  assign bpp       = pga_pkg::eff_bpp(cfg.bits_per_pixel);
  assign geom_ok   = (cfg.glyph_width != 8'd0) && (cfg.glyph_height != 8'd0);
  assign slot_free = !out_valid_r || out_tready;
  assign held_after = held_r - {1'b0, bpp};
  assign row_end   = col_r >= (cfg.glyph_width - 8'd1);
  assign last      = row_end && (row_r >= (cfg.glyph_height - 8'd1));
  // Stop at glyph end, when the buffer runs short, or after eight pixels
  assign run_done  = last || (held_after < {1'b0, bpp}) || (cnt_r == 3'd7);

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      pga_pkg::ST_IDLE: in_tready = 1'b1;
      pga_pkg::ST_RUN:  emit      = slot_free;
      default: ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pga_pkg::ST_IDLE: if (in_acc && geom_ok) state_nxt = pga_pkg::ST_RUN;
      pga_pkg::ST_RUN:  if (emit && run_done) state_nxt = pga_pkg::ST_IDLE;
      default:          state_nxt = pga_pkg::ST_IDLE;
    endcase
  end

  // Bit buffer, position and pixel count
  always_comb begin
    buf_nxt  = buf_r;
    held_nxt = held_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    cnt_nxt  = cnt_r;
    if (in_acc && geom_ok) begin
      buf_nxt  = buf_r | ({in_tdata, 8'h00} >> held_r);
      held_nxt = held_r + 4'd8;
      cnt_nxt  = 3'd0;
    end else if (emit) begin
      cnt_nxt = cnt_r + 3'd1;
      if (last) begin
        buf_nxt  = 16'd0;
        held_nxt = 4'd0;
        col_nxt  = 8'd0;
        row_nxt  = 8'd0;
      end else begin
        buf_nxt  = buf_shifted;
        held_nxt = held_after;
        if (row_end) begin
          col_nxt = 8'd0;
          row_nxt = row_r + 8'd1;
        end else begin
          col_nxt = col_r + 8'd1;
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {alpha, row_r, col_r};
      out_last_nxt  = last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pga_pkg::ST_IDLE;
      buf_r       <= 16'd0;
      held_r      <= 4'd0;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      held_r      <= held_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/pga_checker.sv
// Port-level checker for the packed glyph alpha unpacker, bound to the top level.
// Depends on packed_glyph_alpha_unpacker_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_glyph_alpha_unpacker_defines.svh"

module pga_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pready
);

  // A stalled pixel keeps its payload
  `PGA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output transaction changed")

  // New pixels only come out of a busy sequencer
  `PGA_ASSERT_NOW(a_emit_busy, $rose(out_tvalid), !$past(in_tready), "pixel emitted while idle")

  // Reset empties the output register
  `PGA_ASSERT_NXT_ALL(a_rst_clear, !rst_n, !out_tvalid, "output valid after reset")

  // Config port never inserts wait states
  `PGA_ASSERT_NOW(a_cfg_ready, cfg_psel && cfg_penable, cfg_pready, "config access stalled")

endmodule

bind packed_glyph_alpha_unpacker pga_checker u_pga_checker (.*);

`default_nettype wire
